// ===== rtl/nls_pkg.sv =====
// ----------------------------------------------------------------------------
// nls_pkg
// types and constants shared by the natural log series core
// ----------------------------------------------------------------------------
package nls_pkg;

	localparam logic [63:0] LN2_Q62   = 64'h2C5C85FDF473DE6B;
	localparam logic [63:0] LN1P5_Q62 = 64'h19F323ECBF984BF3;
	localparam logic [63:0] ONE_Q62   = 64'h4000000000000000;
	localparam logic [51:0] SCALE_THRESHOLD = 52'hE666666666666;
	localparam logic [10:0] EXP_BIAS  = 11'd1023;
	localparam logic [10:0] EXP_MAX   = 11'h7FF;

	typedef enum logic [1:0] {
		ST_VALID    = 2'd0,
		ST_ZERO     = 2'd1,
		ST_NEGATIVE = 2'd2,
		ST_UNSUPP   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCALE,
		S_MUL,
		S_DIV,
		S_ACC,
		S_EMUL,
		S_FINAL,
		S_OUT
	} state_t;

	// request to the shared multiplier
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	// request to the shared divider
	typedef struct packed {
		logic        start;
		logic [65:0] num;
		logic [63:0] den;
	} div_req_t;

endpackage

// ===== rtl/nls_if.sv =====
// ----------------------------------------------------------------------------
// nls_in_if / nls_out_if
// valid/ready channels of the natural log series core
// ----------------------------------------------------------------------------
interface nls_in_if (input logic clk);
	logic        valid;
	logic        ready;
	logic [63:0] value_bits;
	modport source (output valid, output value_bits, input ready);
	modport sink   (input valid, input value_bits, output ready);
endinterface

interface nls_out_if (input logic clk);
	logic               valid;
	logic               ready;
	logic signed [63:0] log_value;
	logic [1:0]         status;
	modport source (output valid, output log_value, output status, input ready);
	modport sink   (input valid, input log_value, input status, output ready);
endinterface

// ===== rtl/natural_log_series_core.sv =====
// ----------------------------------------------------------------------------
// natural_log_series_core
// natural logarithm of a double as signed fixed point (units of 2^-53)
// ----------------------------------------------------------------------------
// sequence: special inputs go straight to the output; otherwise each series term takes
//   a product in the 4-step shared multiplier, a quotient in the 66-step shared divider
//   and an accumulate step, after setup, up to MAX_TERMS terms, then the exponent product
// requests: one request at a time; in.ready only while idle and no result is held
// reset: arst_n clears the sequencer and the output valid
module natural_log_series_core #(
	parameter int MAX_TERMS = 512
) (
	input  logic clk,
	input  logic arst_n,
	nls_in_if.sink    in,
	nls_out_if.source out
);
	import nls_pkg::*;

	localparam int IW = $clog2(MAX_TERMS + 1);

	state_t state_q, state_d;

	mul_req_t    mreq;
	div_req_t    dreq;
	logic        mdone, ddone;
	logic [127:0] prod;
	logic [65:0] quo;

	logic [63:0] x_q, pw_q, sum_q, lnm_q;
	logic [IW-1:0] i_q;
	logic [10:0] ex_q;
	logic        scale_q;
	logic        mwait_q, dwait_q;
	logic signed [63:0] res_q;
	status_t     stat_q;
	logic        ovalid_q;

	// input decode
	logic        in_neg;
	logic [10:0] in_ex;
	logic [51:0] in_fr;
	status_t     in_stat;
	assign in_neg = in.value_bits[63];
	assign in_ex  = in.value_bits[62:52];
	assign in_fr  = in.value_bits[51:0];

	always_comb begin
		if (in_ex == EXP_MAX && in_fr != '0)      in_stat = ST_UNSUPP;
		else if (in_ex == '0 && in_fr == '0)      in_stat = ST_ZERO;
		else if (in_neg)                          in_stat = ST_NEGATIVE;
		else if (in_ex == '0 || in_ex == EXP_MAX) in_stat = ST_UNSUPP;
		else                                      in_stat = ST_VALID;
	end

	assign in.ready  = (state_q == S_IDLE) && !ovalid_q;
	assign out.valid = ovalid_q;
	assign out.log_value = res_q;
	assign out.status    = stat_q;

	wire accept = in.valid && in.ready;
	wire ex_ge  = ex_q >= EXP_BIAS;
	wire [10:0] mag_e = ex_ge ? (ex_q - EXP_BIAS) : (EXP_BIAS - ex_q);
	wire [63:0] term = quo[63:0];

	// final combine: |e|*ln2 + lnm (e >= 0) or |e|*ln2 - lnm (e < 0), round, sign
	logic [127:0] fin;
	logic [63:0]  fres;
	always_comb begin
		fin  = ex_ge ? (prod + {64'd0, lnm_q}) : (prod - {64'd0, lnm_q});
		fin  = fin + 128'd256;
		fres = fin[72:9];
		if (!ex_ge) fres = 64'd0 - fres;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (accept) state_d = (in_stat == ST_VALID) ? S_SCALE : S_OUT;
			S_SCALE: state_d = (scale_q) ? S_SCALE : S_MUL;
			S_MUL:   if (mwait_q && mdone) state_d = S_DIV;
			S_DIV:   if (dwait_q && ddone) state_d = S_ACC;
			S_ACC:   state_d = (term == '0 || i_q == IW'(MAX_TERMS)) ? S_EMUL : S_MUL;
			S_EMUL:  if (mwait_q && mdone) state_d = S_FINAL;
			S_FINAL: state_d = S_OUT;
			S_OUT:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// unit requests
	always_comb begin
		mreq = '0;
		dreq = '0;
		case (state_q)
			S_SCALE: begin
				dreq.start = scale_q && !dwait_q;
				dreq.num   = {1'b0, ONE_Q62 + x_q, 1'b0};
				dreq.den   = 64'd3;
			end
			S_MUL: begin
				mreq.start = !mwait_q;
				mreq.a = pw_q;
				mreq.b = x_q;
			end
			S_DIV: begin
				dreq.start = !dwait_q;
				dreq.num   = {2'b0, pw_q};
				dreq.den   = {{(64-IW){1'b0}}, i_q};
			end
			S_EMUL: begin
				mreq.start = !mwait_q;
				mreq.a = {53'd0, mag_e};
				mreq.b = LN2_Q62;
			end
			default: ;
		endcase
	end

	nls_mul u_mul (.clk, .arst_n, .req(mreq), .done(mdone), .prod(prod));
	nls_div u_div (.clk, .arst_n, .req(dreq), .done(ddone), .quo(quo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
			mwait_q  <= 1'b0;
			dwait_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mreq.start) mwait_q <= 1'b1;
			else if (mdone) mwait_q <= 1'b0;
			if (dreq.start) dwait_q <= 1'b1;
			else if (ddone) dwait_q <= 1'b0;
			if (state_q == S_OUT) ovalid_q <= 1'b1;
			else if (out.ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (accept) begin
				ex_q    <= in_ex;
				x_q     <= {in_fr, 10'd0};
				scale_q <= (in_stat == ST_VALID) && (in_fr >= SCALE_THRESHOLD);
				lnm_q   <= '0;
				stat_q  <= in_stat;
				res_q   <= '0;
			end
			S_SCALE: begin
				if (!scale_q) begin
					pw_q  <= x_q;
					sum_q <= x_q;
					i_q   <= IW'(2);
				end else if (dwait_q && ddone) begin
					x_q     <= quo[63:0] - ONE_Q62;
					lnm_q   <= LN1P5_Q62;
					scale_q <= 1'b0;
				end
			end
			S_MUL: if (mwait_q && mdone) pw_q <= {prod[125:64], prod[63:62]};
			S_ACC: begin
				if (term != '0) begin
					sum_q <= i_q[0] ? sum_q + term : sum_q - term;
					i_q   <= i_q + IW'(1);
				end
				if (term == '0 || i_q == IW'(MAX_TERMS))
					lnm_q <= lnm_q + (term == '0 ? sum_q :
						(i_q[0] ? sum_q + term : sum_q - term));
			end
			S_FINAL: res_q <= fres;
			default: ;
		endcase
	end

	// assertions
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in.ready) else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out.valid && !out.ready) |=> out.valid) else $error("result dropped");
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mreq.start && dreq.start)) else $error("two units started");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (i_q >= IW'(2))) else $error("bad term index");
endmodule

// ===== rtl/nls_mul.sv =====
// ----------------------------------------------------------------------------
// nls_mul
// 64x64 -> 128 multiplier, one 32x32 partial product per cycle
// ----------------------------------------------------------------------------
module nls_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  nls_pkg::mul_req_t req,
	output logic              done,
	output logic [127:0]      prod
);
	import nls_pkg::*;

	logic [63:0]  a_q, b_q;
	logic [127:0] acc_q;
	logic [2:0]   cnt_q;
	logic         busy_q;
	logic [31:0]  pa, pb;
	logic [63:0]  pp_q;
	logic [1:0]   idx_q;
	logic         pv_q;

	// partial product for step cnt: a half cnt[1], b half cnt[0]
	assign pa = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign pb = cnt_q[0] ? b_q[63:32] : b_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			pv_q   <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			pv_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q && cnt_q != 3'd4) begin
				pv_q  <= 1'b1;
				cnt_q <= cnt_q + 3'd1;
			end else if (busy_q && !pv_q) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else begin
			if (busy_q && cnt_q != 3'd4) begin
				pp_q  <= pa * pb;
				idx_q <= cnt_q[1:0];
			end
			if (pv_q)
				acc_q <= acc_q + ({64'd0, pp_q} <<
					{({1'b0, idx_q[1]} + {1'b0, idx_q[0]}), 5'd0});
		end
	end

	assign prod = acc_q;
endmodule

// ===== rtl/nls_div.sv =====
// ----------------------------------------------------------------------------
// nls_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module nls_div (
	input  logic              clk,
	input  logic              arst_n,
	input  nls_pkg::div_req_t req,
	output logic              done,
	output logic [65:0]       quo
);
	import nls_pkg::*;

	logic [65:0] q_q;
	logic [63:0] r_q;
	logic [63:0] d_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] trial;
	logic [65:0] diff;

	assign trial = {r_q, q_q[65]};
	assign diff  = {1'b0, trial} - {2'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd66;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.num;
			r_q <= '0;
			d_q <= req.den;
		end else if (busy_q) begin
			if (!diff[65]) begin
				r_q <= diff[63:0];
				q_q <= {q_q[64:0], 1'b1};
			end else begin
				r_q <= trial[63:0];
				q_q <= {q_q[64:0], 1'b0};
			end
		end
	end

	assign quo = q_q;
endmodule
